/* design/hhbp_pkg.sv */
// shared types and constants for the http header byte parser
package hhbp_pkg;

  localparam int unsigned COUNTER_BITS_DEF = 16;
  localparam int unsigned NUM_BITS = 16;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [2:0] TK_START = 3'd0;
  localparam logic [2:0] TK_NAME  = 3'd1;
  localparam logic [2:0] TK_SEP   = 3'd2;
  localparam logic [2:0] TK_VALUE = 3'd3;
  localparam logic [2:0] TK_EOL   = 3'd4;
  localparam logic [2:0] TK_BODY  = 3'd5;
  localparam logic [2:0] TK_DROP  = 3'd6;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_EOL  = 2'd1;
  localparam logic [1:0] ERR_EOM  = 2'd2;

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_NAME  = 6'b000010,
    PH_SEP   = 6'b000100,
    PH_VALUE = 6'b001000,
    PH_BODY  = 6'b010000,
    PH_ERROR = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0]          byte_out;
    logic [2:0]          token_class;
    logic                header_commit;
    logic                headers_done;
    logic [1:0]          error_code;
    logic [NUM_BITS-1:0] line_number;
    logic [NUM_BITS-1:0] column_number;
  } result_t;

endpackage

/* design/hhbp_in_if.sv */
// byte input channel of the http header byte parser
interface hhbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_message;
  logic       last_of_message;

  modport source (output valid, data_byte, first_of_message, last_of_message, input ready);
  modport sink   (input valid, data_byte, first_of_message, last_of_message, output ready);
endinterface

/* design/hhbp_out_if.sv */
// tagged byte output channel of the http header byte parser
interface hhbp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [2:0]  token_class;
  logic        header_commit;
  logic        headers_done;
  logic [1:0]  error_code;
  logic [15:0] line_number;
  logic [15:0] column_number;

  modport source (output valid, byte_out, token_class, header_commit, headers_done,
                  error_code, line_number, column_number, input ready);
  modport sink   (input valid, byte_out, token_class, header_commit, headers_done,
                  error_code, line_number, column_number, output ready);
endinterface

/* design/http_header_byte_parser.sv */
// http header byte parser: tags each message byte and tracks line, column and errors
//
//   channel  direction  carries
//   msg      in         data_byte, first_of_message, last_of_message
//   tag      out        byte_out, token_class, header_commit, headers_done,
//                       error_code, line_number, column_number
//
// one byte per cycle while msg.ready is high: parse state updates in the cycle a byte
// is transferred; its result is registered at that edge in the output or skid register.
// a skid register behind the output register keeps msg ready for one more byte
// while tag is stalled; msg.ready drops only when both are full.
// rst (synchronous) returns the parser to the start line with counters at zero.
module http_header_byte_parser #(
  parameter int unsigned COUNTER_BITS = hhbp_pkg::COUNTER_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  hhbp_in_if.sink    msg,
  hhbp_out_if.source tag
);
  import hhbp_pkg::*;

  phase_t                  phase;
  logic                    name_is_empty;
  logic                    cr_pending;
  logic [COUNTER_BITS-1:0] line_count;
  logic [COUNTER_BITS-1:0] column_count;
  logic [1:0]              error_latch;

  phase_t                  phase_next;
  logic                    name_is_empty_next;
  logic                    cr_pending_next;
  logic [COUNTER_BITS-1:0] line_count_next;
  logic [COUNTER_BITS-1:0] column_count_next;
  logic [1:0]              error_latch_next;

  logic                    out_valid;
  result_t                 out_data;
  logic                    skid_valid;
  result_t                 skid_data;

  phase_t                  ph0;
  logic                    nie0, crp0;
  logic [COUNTER_BITS-1:0] line0, col0, line1, col1, col2;
  logic [1:0]              err0;
  logic                    pend_done, absorbed, is_eol;
  logic [7:0]              c;
  logic [2:0]              tk;
  logic                    commit, done;
  logic [COUNTER_BITS+NUM_BITS-1:0] line_ext, col_ext;
  result_t                 res;
  logic                    push, pop;

  assign c        = msg.data_byte;
  assign is_eol   = (c == CH_CR) || (c == CH_LF);
  assign msg.ready = !skid_valid;
  assign push     = msg.valid && msg.ready;
  assign pop      = out_valid && tag.ready;

  always_comb begin
    // a new message restarts parsing before its first byte is handled
    ph0   = msg.first_of_message ? PH_START : phase;
    nie0  = msg.first_of_message ? 1'b1 : name_is_empty;
    crp0  = msg.first_of_message ? 1'b0 : cr_pending;
    line0 = msg.first_of_message ? '0 : line_count;
    col0  = msg.first_of_message ? '0 : column_count;
    err0  = msg.first_of_message ? ERR_NONE : error_latch;

    // lone cr completes its line once the following byte is not lf
    pend_done = crp0 && (c != CH_LF);
    absorbed  = crp0 && (c == CH_LF);
    line1 = pend_done ? ((line0 == '1) ? line0 : line0 + 1'b1) : line0;
    col1  = pend_done ? '0 : col0;
    col2  = (col1 == '1) ? col1 : col1 + 1'b1;

    phase_next         = ph0;
    name_is_empty_next = nie0;
    error_latch_next   = err0;
    tk     = TK_DROP;
    commit = 1'b0;
    done   = 1'b0;

    case (ph0)
      PH_START: begin
        if (is_eol) begin
          tk = TK_EOL;
          if (!absorbed) begin
            phase_next         = PH_NAME;
            name_is_empty_next = 1'b1;
          end
        end else begin
          tk = TK_START;
        end
      end
      PH_NAME: begin
        if (absorbed) begin
          tk = TK_EOL;
        end else if (c == CH_COLON) begin
          tk         = TK_SEP;
          phase_next = PH_SEP;
        end else if (is_eol) begin
          if (nie0) begin
            tk         = TK_EOL;
            done       = 1'b1;
            phase_next = PH_BODY;
          end else begin
            error_latch_next = ERR_EOL;
            phase_next       = PH_ERROR;
          end
        end else begin
          tk                 = TK_NAME;
          name_is_empty_next = 1'b0;
        end
      end
      PH_SEP: begin
        if (c inside {CH_SP, CH_TAB}) begin
          tk = TK_SEP;
        end else if (is_eol) begin
          error_latch_next = ERR_EOL;
          phase_next       = PH_ERROR;
        end else begin
          tk         = TK_VALUE;
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (is_eol) begin
          tk                 = TK_EOL;
          commit             = 1'b1;
          phase_next         = PH_NAME;
          name_is_empty_next = 1'b1;
        end else begin
          tk = TK_VALUE;
        end
      end
      PH_BODY: begin
        tk = absorbed ? TK_EOL : TK_BODY;
      end
      default: begin
        phase_next = PH_ERROR;
        tk         = TK_DROP;
      end
    endcase

    // cr waits for a possible lf, lf always ends the line
    cr_pending_next   = (c == CH_CR);
    line_count_next   = line1;
    column_count_next = col2;
    if (c == CH_LF) begin
      line_count_next   = (line1 == '1) ? line1 : line1 + 1'b1;
      column_count_next = '0;
    end

    if (msg.last_of_message && phase_next != PH_BODY && phase_next != PH_ERROR) begin
      error_latch_next = ERR_EOM;
      phase_next       = PH_ERROR;
    end

    line_ext = {{NUM_BITS{1'b0}}, line1};
    col_ext  = {{NUM_BITS{1'b0}}, col2};

    res.byte_out      = c;
    res.token_class   = tk;
    res.header_commit = commit;
    res.headers_done  = done;
    res.error_code    = error_latch_next;
    res.line_number   = line_ext[NUM_BITS-1:0];
    res.column_number = col_ext[NUM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      name_is_empty <= 1'b1;
      cr_pending    <= 1'b0;
      line_count    <= '0;
      column_count  <= '0;
      error_latch   <= ERR_NONE;
    end else if (push) begin
      phase         <= phase_next;
      name_is_empty <= name_is_empty_next;
      cr_pending    <= cr_pending_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
      error_latch   <= error_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= res;
      end
    end else if (push) begin
      skid_data <= res;
    end
  end

  assign tag.valid         = out_valid;
  assign tag.byte_out      = out_data.byte_out;
  assign tag.token_class   = out_data.token_class;
  assign tag.header_commit = out_data.header_commit;
  assign tag.headers_done  = out_data.headers_done;
  assign tag.error_code    = out_data.error_code;
  assign tag.line_number   = out_data.line_number;
  assign tag.column_number = out_data.column_number;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    tag.valid |-> !(tag.header_commit && tag.headers_done))
    else $error("header commit and headers done on the same byte");

  a_drop_has_error: assert property (@(posedge clk) disable iff (rst)
    (tag.valid && tag.token_class == TK_DROP) |-> (tag.error_code != ERR_NONE))
    else $error("byte dropped with no error latched");

  a_commit_on_eol: assert property (@(posedge clk) disable iff (rst)
    (tag.valid && (tag.header_commit || tag.headers_done)) |-> (tag.token_class == TK_EOL))
    else $error("header event on a byte that is not a line end");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (push && !msg.first_of_message && error_latch != ERR_NONE)
      |-> (error_latch_next == error_latch))
    else $error("latched error changed within a message");

endmodule

/* verif/hhbp_tag_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the http header byte parser: predicts every tagged byte and checks the output
module hhbp_tag_checker (
  input  logic clk,
  input  logic rst,
  hhbp_in_if   msg,
  hhbp_out_if  tag,
  input  logic stim_done,
  output int   mismatches,
  output int   waiting,
  output int   bytes_seen,
  output int   commits_seen,
  output int   sections_seen,
  output int   eol_errors,
  output int   eom_errors
);
  import hhbp_pkg::*;

  typedef logic [NUM_BITS-1:0] count_t;

  phase_t     hdr_phase;
  logic       name_empty;
  logic       cr_wait;
  count_t     line_cnt;
  count_t     col_cnt;
  logic [1:0] err_latch;

  result_t expected_tags[$];
  int      tags_checked;
  bit      leftovers_checked;

  initial begin
    mismatches = 0;
    waiting = 0;
    bytes_seen = 0;
    commits_seen = 0;
    sections_seen = 0;
    eol_errors = 0;
    eom_errors = 0;
    tags_checked = 0;
    leftovers_checked = 0;
  end

  task automatic report_mismatch(input string text);
    mismatches++;
    if (mismatches <= 30) $display("mismatch: %s", text);
  endtask

  task automatic check_field(input string field, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("tag #%0d %s: got %0h, want %0h", tags_checked, field, got,
                                want));
  endtask

  function automatic count_t step_up(input count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic restart_parse();
    hdr_phase = PH_START;
    name_empty = 1'b1;
    cr_wait = 1'b0;
    line_cnt = '0;
    col_cnt = '0;
    err_latch = ERR_NONE;
  endtask

  // advances the parse state by one byte and returns the tag it should get
  task automatic tag_next_byte(input logic [7:0] c, input logic first, input logic last,
                               output result_t r);
    logic       is_eol;
    logic       absorbed;
    logic       commit;
    logic       done;
    logic [2:0] cls;
    logic [1:0] err_before;
    if (first) restart_parse();
    err_before = err_latch;
    // a lone cr closes its line once the next byte turns out not to be lf
    if (cr_wait && c != CH_LF) begin
      line_cnt = step_up(line_cnt);
      col_cnt = '0;
      cr_wait = 1'b0;
    end
    absorbed = cr_wait && (c == CH_LF);
    is_eol = (c == CH_CR) || (c == CH_LF);
    col_cnt = step_up(col_cnt);
    r.line_number = line_cnt;
    r.column_number = col_cnt;
    cls = TK_DROP;
    commit = 1'b0;
    done = 1'b0;
    case (hdr_phase)
      PH_START: begin
        if (is_eol) begin
          cls = TK_EOL;
          if (!absorbed) begin
            hdr_phase = PH_NAME;
            name_empty = 1'b1;
          end
        end else begin
          cls = TK_START;
        end
      end
      PH_NAME: begin
        if (absorbed) begin
          cls = TK_EOL;
        end else if (c == CH_COLON) begin
          cls = TK_SEP;
          hdr_phase = PH_SEP;
        end else if (is_eol) begin
          if (name_empty) begin
            cls = TK_EOL;
            done = 1'b1;
            hdr_phase = PH_BODY;
          end else begin
            err_latch = ERR_EOL;
            hdr_phase = PH_ERROR;
          end
        end else begin
          cls = TK_NAME;
          name_empty = 1'b0;
        end
      end
      PH_SEP: begin
        if (c == CH_SP || c == CH_TAB) begin
          cls = TK_SEP;
        end else if (is_eol) begin
          err_latch = ERR_EOL;
          hdr_phase = PH_ERROR;
        end else begin
          cls = TK_VALUE;
          hdr_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (is_eol) begin
          cls = TK_EOL;
          commit = 1'b1;
          hdr_phase = PH_NAME;
          name_empty = 1'b1;
        end else begin
          cls = TK_VALUE;
        end
      end
      PH_BODY: begin
        cls = absorbed ? TK_EOL : TK_BODY;
      end
      default: begin
        hdr_phase = PH_ERROR;
        cls = TK_DROP;
      end
    endcase
    if (c == CH_CR) begin
      cr_wait = 1'b1;
    end else if (c == CH_LF) begin
      line_cnt = step_up(line_cnt);
      col_cnt = '0;
      cr_wait = 1'b0;
    end
    if (last && hdr_phase != PH_BODY && hdr_phase != PH_ERROR) begin
      err_latch = ERR_EOM;
      hdr_phase = PH_ERROR;
    end
    if (err_before == ERR_NONE && err_latch == ERR_EOL) eol_errors++;
    if (err_before == ERR_NONE && err_latch == ERR_EOM) eom_errors++;
    r.byte_out = c;
    r.token_class = cls;
    r.header_commit = commit;
    r.headers_done = done;
    r.error_code = err_latch;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      restart_parse();
      expected_tags.delete();
    end else begin
      if (msg.valid && msg.ready) begin
        tag_next_byte(msg.data_byte, msg.first_of_message, msg.last_of_message, want);
        expected_tags.push_back(want);
        bytes_seen++;
        if (want.header_commit) commits_seen++;
        if (want.headers_done) sections_seen++;
      end
      if (tag.valid && tag.ready) begin
        if (expected_tags.size() == 0) begin
          report_mismatch($sformatf("tag with no byte pending, byte_out %02h", tag.byte_out));
        end else begin
          want = expected_tags.pop_front();
          check_field("byte_out", 16'(tag.byte_out), 16'(want.byte_out));
          check_field("token_class", 16'(tag.token_class), 16'(want.token_class));
          check_field("header_commit", 16'(tag.header_commit), 16'(want.header_commit));
          check_field("headers_done", 16'(tag.headers_done), 16'(want.headers_done));
          check_field("error_code", 16'(tag.error_code), 16'(want.error_code));
          check_field("line_number", 16'(tag.line_number), 16'(want.line_number));
          check_field("column_number", 16'(tag.column_number), 16'(want.column_number));
          tags_checked++;
        end
      end
      if (stim_done && !leftovers_checked) begin
        leftovers_checked = 1;
        if (expected_tags.size() != 0)
          report_mismatch($sformatf("%0d tags never came out", expected_tags.size()));
      end
    end
    waiting = expected_tags.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// testbench top for the http header byte parser: byte stimulus, output stalls and verdict
module tb;
  import hhbp_pkg::*;

  localparam int RANDOM_BYTES   = 1900;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_LIMIT    = 1000;
  localparam int TAIL_CYCLES    = 16;

  typedef struct {
    logic [7:0] b;
    logic       first;
    logic       last;
  } msg_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic stim_done;

  int mismatches, waiting, bytes_seen, commits_seen, sections_seen, eol_errors, eom_errors;
  int src_mode, sink_mode;
  int idle_cycles;
  int sent_random;
  msg_byte_t msg_bytes[$];

  hhbp_in_if  msg_if ();
  hhbp_out_if tag_if ();

  http_header_byte_parser dut (
    .clk (clk),
    .rst (rst),
    .msg (msg_if.sink),
    .tag (tag_if.source)
  );

  hhbp_tag_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .msg           (msg_if),
    .tag           (tag_if),
    .stim_done     (stim_done),
    .mismatches    (mismatches),
    .waiting       (waiting),
    .bytes_seen    (bytes_seen),
    .commits_seen  (commits_seen),
    .sections_seen (sections_seen),
    .eol_errors    (eol_errors),
    .eom_errors    (eom_errors)
  );

  always #1 clk = ~clk;

  // mode 0 never waits, mode 1 waits now and then, mode 2 waits on most items
  function automatic int draw_gap(input int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
      default: return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF || b == CH_COLON);
    return b;
  endfunction

  function automatic logic [7:0] pick_any_byte();
    if ($urandom_range(0, 2) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_COLON;
      3: return CH_SP;
      default: return CH_TAB;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    msg_byte_t item;
    item.b = b;
    item.first = 1'b0;
    item.last = 1'b0;
    msg_bytes.push_back(item);
  endtask

  task automatic add_eol();
    case ($urandom_range(0, 2))
      0: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
      1: add_byte(CH_LF);
      default: add_byte(CH_CR);
    endcase
  endtask

  task automatic frame_message();
    foreach (msg_bytes[i]) begin
      msg_bytes[i].first = 1'b0;
      msg_bytes[i].last = 1'b0;
    end
    msg_bytes[0].first = 1'b1;
    msg_bytes[msg_bytes.size()-1].last = 1'b1;
  endtask

  task automatic build_header_message();
    logic [7:0] b;
    repeat ($urandom_range(0, 6)) add_byte(pick_text_byte());
    add_eol();
    repeat ($urandom_range(0, 4)) begin
      // an empty name now and then: the colon opens the line
      if ($urandom_range(0, 5) != 0) repeat ($urandom_range(1, 6)) add_byte(pick_text_byte());
      add_byte(CH_COLON);
      repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
      do b = pick_text_byte();
      while (b == CH_SP || b == CH_TAB);
      add_byte(b);
      repeat ($urandom_range(0, 5)) add_byte(pick_text_byte());
      add_eol();
    end
    add_eol();
    repeat ($urandom_range(0, 8)) add_byte(pick_any_byte());
    frame_message();
  endtask

  task automatic build_noise();
    msg_byte_t item;
    repeat ($urandom_range(1, 20)) begin
      item.b = pick_any_byte();
      item.first = ($urandom_range(0, 7) == 0);
      item.last = ($urandom_range(0, 7) == 0);
      msg_bytes.push_back(item);
    end
  endtask

  task automatic break_message();
    msg_byte_t item;
    int keep;
    case ($urandom_range(0, 4))
      0: begin
        keep = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
        frame_message();
      end
      1: msg_bytes[$urandom_range(0, msg_bytes.size()-1)].b = pick_any_byte();
      2: begin
        item.b = $urandom_range(0, 1) ? CH_CR : CH_LF;
        item.first = 1'b0;
        item.last = 1'b0;
        msg_bytes.insert($urandom_range(1, msg_bytes.size()), item);
        frame_message();
      end
      // no start marker: the bytes run on from where the last message stopped
      3: msg_bytes[0].first = 1'b0;
      default: msg_bytes[$urandom_range(0, msg_bytes.size()-1)].last = 1'b1;
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    int gap;
    gap = draw_gap(src_mode);
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_if.data_byte <= b;
    msg_if.first_of_message <= first;
    msg_if.last_of_message <= last;
    msg_if.valid <= 1'b1;
    do @(posedge clk);
    while (!msg_if.ready);
    @(negedge clk);
  endtask

  task automatic send_queued();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i].b, msg_bytes[i].first, msg_bytes[i].last);
    msg_bytes.delete();
  endtask

  task automatic wait_for_tags();
    msg_if.valid <= 1'b0;
    do @(negedge clk);
    while (waiting != 0);
  endtask

  // output side: hold ready low for a drawn number of cycles before each transfer
  initial begin
    int gap;
    tag_if.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      gap = draw_gap(sink_mode);
      if (gap > 0) begin
        tag_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      tag_if.ready <= 1'b1;
      do @(posedge clk);
      while (!tag_if.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_if.valid && msg_if.ready) || (tag_if.valid && tag_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int drain;
    stim_done = 1'b0;
    idle_cycles = 0;
    msg_if.valid = 1'b0;
    msg_if.data_byte = '0;
    msg_if.first_of_message = 1'b0;
    msg_if.last_of_message = 1'b0;
    src_mode = 1;
    sink_mode = 2;
    sent_random = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extreme bytes in the start line, empty name with tab, lone cr, crlf, body cr and lf
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_LF);
    add_byte(CH_COLON);
    add_byte(CH_TAB);
    add_byte("v");
    add_byte(CH_CR);
    add_byte("n");
    add_byte(CH_COLON);
    add_byte(CH_SP);
    add_byte("x");
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_byte(CH_CR);
    add_byte("z");
    frame_message();
    send_queued();
    // line end inside a name, then a byte dropped after the error
    add_byte("a");
    add_byte(CH_LF);
    add_byte("k");
    add_byte(CH_LF);
    add_byte("x");
    frame_message();
    send_queued();
    // line end right after the colon
    add_byte("b");
    add_byte(CH_LF);
    add_byte("k");
    add_byte(CH_COLON);
    add_byte(CH_LF);
    frame_message();
    send_queued();
    // message ends before the headers do, then a stray byte with no new start
    add_byte("t");
    add_byte(CH_LF);
    frame_message();
    add_byte("y");
    send_queued();
    wait_for_tags();

    while (sent_random < RANDOM_BYTES) begin
      src_mode = $urandom_range(0, 2);
      sink_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) begin
        build_noise();
      end else begin
        build_header_message();
        if ($urandom_range(0, 9) < 3) break_message();
      end
      sent_random += msg_bytes.size();
      send_queued();
      if ($urandom_range(0, 15) == 0) wait_for_tags();
    end

    msg_if.valid <= 1'b0;
    drain = 0;
    while (waiting != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    stim_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("covered %0d bytes over directed cases and random messages with stalls",
             bytes_seen);
    $display("  %0d header pairs, %0d sections closed, %0d line-end, %0d early-end errors",
             commits_seen, sections_seen, eol_errors, eom_errors);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
